@@ src/chtbl_pkg.sv @@
package chtbl_pkg;

   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 64;
   localparam int MODE_BITS = 2;
   localparam int STAT_BITS = 2;

   localparam int BUCKETS_DEFAULT      = 10;
   localparam int POOL_NODES_DEFAULT   = 128;
   localparam int PAYLOAD_BITS_DEFAULT = 64;

   typedef logic [MODE_BITS-1:0] mode_type;
   typedef logic [STAT_BITS-1:0] status_type;

   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_SEARCH = 2'd1;
   localparam mode_type MODE_CLEAR  = 2'd2;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FOUND = 2'd1;
   localparam status_type STATUS_MISS  = 2'd2;
   localparam status_type STATUS_FULL  = 2'd3;

endpackage

@@ src/chained_hash_table_unit.sv @@
// Chained hash table with a fixed node pool.
// Request channel (req_valid/req_ready): one beat carries mode, key and data.
//   Insert links a new node at the head of bucket key % BUCKETS; search walks
//   that chain and returns the newest matching payload; clear empties all.
// Response channel (rsp_valid/rsp_ready): exactly one beat per request, with
//   status (done, found, not found, pool full) and found_data (zero unless found).
// One request is in flight at a time. The bucket index comes from a reciprocal
//   multiply followed by a remainder step. Clear, unused modes and a full-pool
//   insert respond without hashing; a search visits one chain node per cycle
//   (one node memory read each), and a miss on an empty bucket ends at the
//   head without walking the chain.
// The response sits in an output register; a stalled receiver holds it there
//   while the next request is taken and processed up to its own response,
//   which then waits until the register frees.
// Reset (synchronous) empties every bucket and the pool at once; no clearing
//   pass is needed, so a request may be sent in the first cycle after reset.
module chained_hash_table_unit #(
   parameter int BUCKETS      = chtbl_pkg::BUCKETS_DEFAULT,
   parameter int POOL_NODES   = chtbl_pkg::POOL_NODES_DEFAULT,
   parameter int PAYLOAD_BITS = chtbl_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [chtbl_pkg::MODE_BITS-1:0] req_mode,
   input  logic [chtbl_pkg::KEY_BITS-1:0]  req_entry_key,
   input  logic [chtbl_pkg::DATA_BITS-1:0] req_entry_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [chtbl_pkg::STAT_BITS-1:0] rsp_status,
   output logic [chtbl_pkg::DATA_BITS-1:0] rsp_found_data
);

   import chtbl_pkg::*;

   localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW     = $clog2(POOL_NODES);
   localparam int FW     = $clog2(POOL_NODES + 1);
   localparam int PB     = PAYLOAD_BITS;
   localparam int NODE_W = 1 + NW + KEY_BITS + PB;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_HEAD,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [PB-1:0]       data_ff, data_in;
   logic [BW-1:0]       bucket_ff, bucket_in;
   logic [BUCKETS-1:0]  hvalid_ff, hvalid_in;
   logic [FW-1:0]       fill_ff, fill_in;
   status_type          res_status_ff, res_status_in;
   logic [PB-1:0]       res_data_ff, res_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                mod_start, mod_done;
   logic [BW-1:0]       mod_bucket;

   logic                head_wr_en;
   logic [NW-1:0]       head_rdata;

   logic                node_wr_en;
   logic [NODE_W-1:0]   node_wdata, node_rdata;
   logic [NW-1:0]       node_rd_addr;

   logic                node_link_valid;
   logic [NW-1:0]       node_link;
   logic [KEY_BITS-1:0] node_key;
   logic [PB-1:0]       node_payload;

   assign {node_link_valid, node_link, node_key, node_payload} = node_rdata;

   chtbl_mod #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .key    (req_entry_key),
      .done   (mod_done),
      .bucket (mod_bucket)
   );

   chtbl_ram #(
      .WIDTH (NW),
      .DEPTH (BUCKETS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (bucket_ff),
      .wr_data (fill_ff[NW-1:0]),
      .rd_addr (mod_bucket),
      .rd_data (head_rdata)
   );

   chtbl_ram #(
      .WIDTH (NODE_W),
      .DEPTH (POOL_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (fill_ff[NW-1:0]),
      .wr_data (node_wdata),
      .rd_addr (node_rd_addr),
      .rd_data (node_rdata)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign node_rd_addr = (state_ff == ST_HEAD) ? head_rdata : node_link;
   assign node_wdata   = {hvalid_ff[bucket_ff], head_rdata, key_ff, data_ff};

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      data_in       = data_ff;
      bucket_in     = bucket_ff;
      hvalid_in     = hvalid_ff;
      fill_in       = fill_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      mod_start     = 1'b0;
      head_wr_en    = 1'b0;
      node_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_mode;
               key_in        = req_entry_key;
               data_in       = req_entry_data[PB-1:0];
               res_status_in = STATUS_DONE;
               res_data_in   = '0;
               if (req_mode == MODE_CLEAR) begin
                  hvalid_in = '0;
                  fill_in   = '0;
                  state_in  = ST_FINISH;
               end else if (req_mode == MODE_INSERT && fill_ff == FW'(POOL_NODES)) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_FINISH;
               end else if (req_mode == MODE_INSERT || req_mode == MODE_SEARCH) begin
                  mod_start = 1'b1;
                  state_in  = ST_HASH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_HASH: begin
            if (mod_done) begin
               bucket_in = mod_bucket;
               state_in  = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (mode_ff == MODE_INSERT) begin
               node_wr_en           = 1'b1;
               head_wr_en           = 1'b1;
               hvalid_in[bucket_ff] = 1'b1;
               fill_in              = fill_ff + 1'b1;
               state_in             = ST_FINISH;
            end else if (hvalid_ff[bucket_ff]) begin
               state_in = ST_WALK;
            end else begin
               res_status_in = STATUS_MISS;
               state_in      = ST_FINISH;
            end
         end
         ST_WALK: begin
            if (node_key == key_ff) begin
               res_status_in = STATUS_FOUND;
               res_data_in   = node_payload;
               state_in      = ST_FINISH;
            end else if (!node_link_valid) begin
               res_status_in = STATUS_MISS;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = DATA_BITS'(res_data_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hvalid_ff    <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hvalid_ff    <= hvalid_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      bucket_ff     <= bucket_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_data = rsp_data_ff;

endmodule

@@ src/chtbl_ram.sv @@
module chtbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ src/chtbl_mod.sv @@
module chtbl_mod #(
   parameter int BUCKETS = chtbl_pkg::BUCKETS_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [chtbl_pkg::KEY_BITS-1:0]                 key,
   output logic                                           done,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

   import chtbl_pkg::*;

   localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
   localparam int SH    = KEY_BITS + LW;
   localparam int RW    = KEY_BITS + 1;
   localparam int PW    = KEY_BITS + RW;
   // ceil(2^SH / BUCKETS): the quotient is exact for every key
   localparam logic [RW-1:0] RECIP =
      RW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

   logic                s1_ff, s1_in;
   logic                s2_ff, s2_in;
   logic                done_ff, done_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] quot_ff, quot_in;
   logic [BW-1:0]       rem_ff, rem_in;
   logic [PW-1:0]       prod;
   logic [KEY_BITS-1:0] back;
   logic [KEY_BITS-1:0] diff;

   // stage s1: quotient by reciprocal multiply; stage s2: remainder
   assign prod = PW'(key_ff) * PW'(RECIP);
   assign back = quot_ff * KEY_BITS'(BUCKETS);
   assign diff = key_ff - back;

   always_comb begin
      s1_in   = start;
      s2_in   = s1_ff;
      done_in = s2_ff;
      key_in  = start ? key : key_ff;
      quot_in = s1_ff ? KEY_BITS'(prod >> SH) : quot_ff;
      rem_in  = s2_ff ? diff[BW-1:0] : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         done_ff <= done_in;
      end
      key_ff  <= key_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule
